### hdl/tlfd_pkg.sv
// Shared types and constants of the type-length frame deframer.
package tlfd_pkg;

	localparam logic [7:0] TYPE_QUEUED   = 8'h51;
	localparam logic [7:0] TYPE_REALTIME = 8'h52;
	localparam logic [2:0] HEADER_BYTES  = 3'd5;

	localparam logic KIND_DATA       = 1'b0;
	localparam logic KIND_LINK_RESET = 1'b1;

	localparam int CFG_IDX_W = 2;

	localparam logic [31:0] MAX_FRAME_RESET    = 32'd1048576;
	localparam logic [31:0] MAX_QUEUED_RESET   = 32'd65536;
	localparam logic [31:0] MAX_REALTIME_RESET = 32'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_FRAME    = 2'd0,
		REG_MAX_QUEUED   = 2'd1,
		REG_MAX_REALTIME = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_TOTAL      = 3'd1,
		ERR_TYPE_LIMIT = 3'd2,
		ERR_UNKNOWN    = 3'd3,
		ERR_TRUNCATED  = 3'd4
	} err_t;

	typedef struct packed {
		logic [31:0] max_frame;
		logic [31:0] max_queued;
		logic [31:0] max_realtime;
	} limits_t;

	typedef struct packed {
		logic       frame_type;
		logic [7:0] payload_byte;
		logic       empty_frame;
		logic       last;
		err_t       error;
	} result_t;

endpackage

### hdl/tlfd_ifs.sv
// Channel interfaces of the type-length frame deframer.
interface tlfd_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface tlfd_out_if;
	logic       valid;
	logic       ready;
	logic       frame_type;
	logic [7:0] payload_byte;
	logic       empty_frame;
	logic       last;
	logic [2:0] error;
	modport source (output valid, output frame_type, output payload_byte,
		output empty_frame, output last, output error, input ready);
	modport sink (input valid, input frame_type, input payload_byte,
		input empty_frame, input last, input error, output ready);
endinterface

interface tlfd_cfg_if;
	import tlfd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

### hdl/tlfd_cfg_regs.sv
// Limit registers written through the configuration channel.
module tlfd_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	tlfd_cfg_if.sink         cfg,
	output tlfd_pkg::limits_t limits
);
	import tlfd_pkg::*;

	limits_t limits_q;

	assign cfg.ready = 1'b1;
	assign limits    = limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.max_frame    <= MAX_FRAME_RESET;
			limits_q.max_queued   <= MAX_QUEUED_RESET;
			limits_q.max_realtime <= MAX_REALTIME_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAX_FRAME:    limits_q.max_frame    <= cfg.wdata;
				REG_MAX_QUEUED:   limits_q.max_queued   <= cfg.wdata;
				REG_MAX_REALTIME: limits_q.max_realtime <= cfg.wdata;
				default: ;
			endcase
		end
	end
endmodule

### hdl/tlfd_parser.sv
// Header parser and payload counter: parse state and the result of one beat.
module tlfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              kind,
	input  logic [7:0]        data_byte,
	input  tlfd_pkg::limits_t limits,
	output logic              produce,
	output tlfd_pkg::result_t res
);
	import tlfd_pkg::*;

	logic [2:0]  hc_q, hc_d;
	logic [7:0]  type_q, type_d;
	logic [31:0] len_q, len_d;
	logic [31:0] left_q, left_d;
	logic        halted_q, halted_d;
	logic [31:0] len_new;
	logic        is_q, is_r;
	err_t        hdr_err;

	assign len_new = {len_q[23:0], data_byte};
	assign is_q    = (type_q == TYPE_QUEUED);
	assign is_r    = (type_q == TYPE_REALTIME);

	// The total limit wins over the type limit, which wins over an unknown type.
	always_comb begin
		if (len_new > limits.max_frame)
			hdr_err = ERR_TOTAL;
		else if (is_q && len_new > limits.max_queued)
			hdr_err = ERR_TYPE_LIMIT;
		else if (is_r && len_new > limits.max_realtime)
			hdr_err = ERR_TYPE_LIMIT;
		else if (!is_q && !is_r)
			hdr_err = ERR_UNKNOWN;
		else
			hdr_err = ERR_NONE;
	end

	always_comb begin
		hc_d     = hc_q;
		type_d   = type_q;
		len_d    = len_q;
		left_d   = left_q;
		halted_d = halted_q;
		produce  = 1'b0;
		res.frame_type   = is_r;
		res.payload_byte = 8'd0;
		res.empty_frame  = 1'b0;
		res.last         = 1'b0;
		res.error        = ERR_NONE;
		if (kind == KIND_LINK_RESET) begin
			produce   = !halted_q && (hc_q != 3'd0);
			res.error = ERR_TRUNCATED;
			hc_d      = 3'd0;
			type_d    = 8'd0;
			len_d     = 32'd0;
			left_d    = 32'd0;
			halted_d  = 1'b0;
		end else if (halted_q) begin
			produce = 1'b0;
		end else if (hc_q == HEADER_BYTES) begin
			produce          = 1'b1;
			res.payload_byte = data_byte;
			left_d           = left_q - 32'd1;
			if (left_q == 32'd1) begin
				res.last = 1'b1;
				hc_d     = 3'd0;
				len_d    = 32'd0;
			end
		end else if (hc_q == 3'd0) begin
			type_d = data_byte;
			len_d  = 32'd0;
			hc_d   = 3'd1;
		end else begin
			len_d = len_new;
			hc_d  = hc_q + 3'd1;
			if (hc_q == HEADER_BYTES - 3'd1) begin
				if (hdr_err != ERR_NONE) begin
					produce   = 1'b1;
					res.error = hdr_err;
					halted_d  = 1'b1;
					hc_d      = 3'd0;
					left_d    = 32'd0;
				end else if (len_new == 32'd0) begin
					produce         = 1'b1;
					res.empty_frame = 1'b1;
					res.last        = 1'b1;
					hc_d            = 3'd0;
				end else begin
					left_d = len_new;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q     <= 3'd0;
			type_q   <= 8'd0;
			len_q    <= 32'd0;
			left_q   <= 32'd0;
			halted_q <= 1'b0;
		end else if (step) begin
			hc_q     <= hc_d;
			type_q   <= type_d;
			len_q    <= len_d;
			left_q   <= left_d;
			halted_q <= halted_d;
		end
	end

`ifndef ASSERT_OFF
	a_payload_pending: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q == HEADER_BYTES |-> left_q != 32'd0)
		else $error("payload phase with no bytes left");
	a_halt_clears_header: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> hc_q == 3'd0)
		else $error("halted with a header in progress");
	a_link_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && kind == KIND_LINK_RESET |=> hc_q == 3'd0 && !halted_q)
		else $error("link reset left parse state behind");
`endif
endmodule

### hdl/tlfd_out_reg.sv
// Result register that drives the output channel.
module tlfd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tlfd_pkg::result_t res,
	output logic              can_load,
	tlfd_out_if.source        frames
);
	import tlfd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign can_load            = !valid_q || frames.ready;
	assign frames.valid        = valid_q;
	assign frames.frame_type   = res_q.frame_type;
	assign frames.payload_byte = res_q.payload_byte;
	assign frames.empty_frame  = res_q.empty_frame;
	assign frames.last         = res_q.last;
	assign frames.error        = res_q.error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			res_q <= res;
		end
	end
endmodule

### hdl/type_length_frame_deframer.sv
// Top level of the type-length frame deframer.
//
// The stream channel takes one beat per received byte (kind 0) or per link
// reset (kind 1). Each frame on the link is a type byte, 'Q' or 'R', then a
// four-byte big-endian length and that many payload bytes. The frames
// channel gives one beat per payload byte, with last on the final one, one
// empty marker for a zero-length frame, and error beats for an oversized
// length, an unknown type or a frame cut short by a link reset. After a
// header error every byte is dropped until the next link reset.
// An accepted beat is held in the input register and parsed from there, and
// its result, if any, is loaded into the result register that drives the
// frames channel. One beat is taken in every cycle while the frames
// receiver keeps ready high; the single parser state update per byte sets
// this rate. When the receiver stalls, the result register holds its beat
// and the input register fills, then stream ready drops until it drains.
// The configuration channel writes the three length limits and is always
// ready; it is meant to be written while no frame is in flight.
// Reset clears the parse state, the halt and the valid flags of both
// pipeline registers and loads the default limits.
module type_length_frame_deframer (
	input  logic     clk,
	input  logic     arst_n,
	tlfd_in_if.sink  stream,
	tlfd_out_if.source frames,
	tlfd_cfg_if.sink cfg
);
	import tlfd_pkg::*;

	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;
	logic       can_load;
	logic       advance;
	logic       produce;
	limits_t    limits;
	result_t    res;

	// The registered beat moves on whenever the result register has room,
	// whether or not it yields a result.
	assign advance      = valid_s1 && can_load;
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			kind_s1 <= stream.kind;
			byte_s1 <= stream.data_byte;
		end
	end

	tlfd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.limits (limits)
	);

	tlfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.kind      (kind_s1),
		.data_byte (byte_s1),
		.limits    (limits),
		.produce   (produce),
		.res       (res)
	);

	tlfd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && produce),
		.res      (res),
		.can_load (can_load),
		.frames   (frames)
	);
endmodule
